>>> rtl/frb_pkg.sv
// shared types and codes for the framed byte ring buffer
`default_nettype none

package frb_pkg;

  // request codes as they arrive on the input channel
  localparam logic [2:0] REQ_OPEN  = 3'd0;
  localparam logic [2:0] REQ_WRITE = 3'd1;
  localparam logic [2:0] REQ_CLOSE = 3'd2;
  localparam logic [2:0] REQ_PEEK  = 3'd3;
  localparam logic [2:0] REQ_POP   = 3'd4;

  // decoded operations handed to the back end
  typedef logic [2:0] op_t;
  localparam op_t OP_OPEN  = 3'd0;
  localparam op_t OP_WRITE = 3'd1;
  localparam op_t OP_CLOSE = 3'd2;
  localparam op_t OP_PEEK  = 3'd3;
  localparam op_t OP_POP   = 3'd4;
  localparam op_t OP_NOP   = 3'd5;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOSPACE   = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_UNDERFLOW = 3'd3;
  localparam logic [2:0] ST_FORMAT    = 3'd4;

  // width of the space needed to open an event (id bytes plus payload)
  localparam int NEED_W = 9;

  // classified request as queued between front and back
  typedef struct packed {
    op_t               op;
    logic [15:0]       object_id;
    logic [7:0]        frame_len;
    logic [7:0]        write_byte;
    logic [7:0]        peek_offset;
    logic [NEED_W-1:0] open_need;
  } req_t;

endpackage

`default_nettype wire

>>> rtl/framed_byte_ring_buffer.sv
// framed byte ring buffer top level: request front end and execution back end
//
//   channel   handshake             payload
//   input     in_valid / in_ready   req_type object_id frame_len write_byte peek_offset
//   output    out_valid / out_ready status read_byte fill_count free_space
//
// the back end takes one queued request at a time; an accepted open writes its id bytes
// in S_IDWR, successful peek and pop pass S_READ for the registered store read, and every
// other request (write, close, no-op, refused open, underflow) goes straight to S_DONE.
// the single-port byte store allows one byte per cycle, which sets the open time.
// rst is synchronous; the store is not cleared and needs no clearing pass.
// a two-entry queue keeps requests flowing in while a result waits on out_ready.
`default_nettype none

module framed_byte_ring_buffer import frb_pkg::*; #(
  parameter int DEPTH    = 256,
  parameter int ID_BYTES = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  req_type,
  input  wire logic [15:0] object_id,
  input  wire logic [7:0]  frame_len,
  input  wire logic [7:0]  write_byte,
  input  wire logic [7:0]  peek_offset,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [7:0]       read_byte,
  output logic [7:0]       fill_count,
  output logic [7:0]       free_space
);

  logic q_valid;
  req_t q_item;
  logic q_pop;

  // intake and queue
  frb_front #(
    .ID_BYTES (ID_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .object_id   (object_id),
    .frame_len   (frame_len),
    .write_byte  (write_byte),
    .peek_offset (peek_offset),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  // execution and result
  frb_back #(
    .DEPTH    (DEPTH),
    .ID_BYTES (ID_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .read_byte  (read_byte),
    .fill_count (fill_count),
    .free_space (free_space)
  );

endmodule

`default_nettype wire

>>> rtl/frb_front.sv
// request intake: decode, space requirement and a two-entry queue
`default_nettype none

module frb_front import frb_pkg::*; #(
  parameter int ID_BYTES = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  req_type,
  input  wire logic [15:0] object_id,
  input  wire logic [7:0]  frame_len,
  input  wire logic [7:0]  write_byte,
  input  wire logic [7:0]  peek_offset,
  output logic             q_valid,
  output req_t             q_item,
  input  wire logic        q_pop
);

  req_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  req_t       dec;
  logic       push;

  // classify the incoming request
  always_comb begin
    dec.object_id   = object_id;
    dec.frame_len   = frame_len;
    dec.write_byte  = write_byte;
    dec.peek_offset = peek_offset;
    dec.open_need   = NEED_W'(ID_BYTES) + {1'b0, frame_len};
    case (req_type)
      REQ_OPEN:  dec.op = OP_OPEN;
      REQ_WRITE: dec.op = OP_WRITE;
      REQ_CLOSE: dec.op = OP_CLOSE;
      REQ_PEEK:  dec.op = OP_PEEK;
      REQ_POP:   dec.op = OP_POP;
      default:   dec.op = OP_NOP;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entries[rd_ptr];

  // queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= dec;
    end
  end

  // queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (!push && q_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/frb_back.sv
// request execution: ring store, pointers, event tracking, result register
`default_nettype none

module frb_back import frb_pkg::*; #(
  parameter int DEPTH    = 256,
  parameter int ID_BYTES = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  input  wire req_t       q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      status,
  output logic [7:0]      read_byte,
  output logic [7:0]      fill_count,
  output logic [7:0]      free_space
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = (AW > NEED_W) ? AW + 1 : NEED_W + 1;
  localparam int IDW = $clog2(ID_BYTES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_IDWR = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [7:0]     mem [DEPTH];
  logic [7:0]     rd_data;
  logic           mem_we;
  logic [AW-1:0]  mem_addr;
  logic [7:0]     mem_wdata;

  logic [1:0]     state;
  logic [AW-1:0]  write_pointer;
  logic [AW-1:0]  read_pointer;
  logic [7:0]     payload_count;
  logic [7:0]     expected_length;
  logic           event_open;
  logic [IDW-1:0] id_idx;
  logic [15:0]    cur_id;
  logic [7:0]     cur_len;
  logic [2:0]     res_status;
  logic [7:0]     res_byte;

  logic [AW-1:0]  fill;
  logic [AW-1:0]  free;
  logic [CW-1:0]  fill_ext;
  logic [CW-1:0]  free_ext;
  logic [CW-1:0]  need_ext;
  logic [CW-1:0]  offs_ext;
  logic [CW-1:0]  peek_sum;
  logic [7:0]     id_byte;
  logic           out_load;

  // occupancy from the pointers, one slot kept empty
  assign fill     = write_pointer - read_pointer;
  assign free     = read_pointer - write_pointer - AW'(1);
  assign fill_ext = {{(CW-AW){1'b0}}, fill};
  assign free_ext = {{(CW-AW){1'b0}}, free};
  assign need_ext = {{(CW-NEED_W){1'b0}}, q_item.open_need};
  assign offs_ext = {{(CW-8){1'b0}}, q_item.peek_offset};
  assign peek_sum = {{(CW-AW){1'b0}}, read_pointer} + offs_ext;

  // id byte for the current step, little-endian, zero above the second
  always_comb begin
    if (id_idx == IDW'(0)) begin
      id_byte = cur_id[7:0];
    end else if (id_idx == IDW'(1)) begin
      id_byte = cur_id[15:8];
    end else begin
      id_byte = 8'd0;
    end
  end

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = write_pointer;
    mem_wdata = q_item.write_byte;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            OP_WRITE: mem_we = (free != '0);
            OP_PEEK:  mem_addr = peek_sum[AW-1:0];
            OP_POP:   mem_addr = read_pointer;
            default:  mem_we = 1'b0;
          endcase
        end
      end
      S_IDWR: begin
        mem_we    = 1'b1;
        mem_wdata = id_byte;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // single-port byte store with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[mem_addr];
  end

  // sequencer and ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      write_pointer   <= '0;
      read_pointer    <= '0;
      payload_count   <= 8'd0;
      expected_length <= 8'd0;
      event_open      <= 1'b0;
      id_idx          <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            res_status <= ST_OK;
            res_byte   <= 8'd0;
            state      <= S_DONE;
            case (q_item.op)
              OP_OPEN: begin
                if (free_ext < need_ext) begin
                  res_status <= ST_NOSPACE;
                end else begin
                  cur_id  <= q_item.object_id;
                  cur_len <= q_item.frame_len;
                  id_idx  <= '0;
                  state   <= S_IDWR;
                end
              end
              OP_WRITE: begin
                if (free == '0) begin
                  res_status <= ST_OVERFLOW;
                end else begin
                  write_pointer <= write_pointer + AW'(1);
                  if (payload_count != 8'hff) begin
                    payload_count <= payload_count + 8'd1;
                  end
                end
              end
              OP_CLOSE: begin
                if (!event_open || payload_count != expected_length) begin
                  res_status <= ST_FORMAT;
                end
                event_open <= 1'b0;
              end
              OP_PEEK: begin
                if (offs_ext >= fill_ext) begin
                  res_status <= ST_UNDERFLOW;
                end else begin
                  state <= S_READ;
                end
              end
              OP_POP: begin
                if (fill == '0) begin
                  res_status <= ST_UNDERFLOW;
                end else begin
                  read_pointer <= read_pointer + AW'(1);
                  state        <= S_READ;
                end
              end
              default: res_status <= ST_OK;
            endcase
          end
        end
        S_IDWR: begin
          write_pointer <= write_pointer + AW'(1);
          if (id_idx == IDW'(ID_BYTES - 1)) begin
            payload_count   <= 8'd0;
            expected_length <= cur_len;
            event_open      <= 1'b1;
            state           <= S_DONE;
          end else begin
            id_idx <= id_idx + IDW'(1);
          end
        end
        S_READ: begin
          res_byte <= rd_data;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status     <= res_status;
      read_byte  <= res_byte;
      fill_count <= fill_ext[7:0];
      free_space <= free_ext[7:0];
    end
  end

endmodule

`default_nettype wire

>>> tb/framed_byte_ring_buffer_tb.sv
// self-checking testbench for the framed byte ring buffer
`timescale 1ns / 100ps

module framed_byte_ring_buffer_tb;
  import frb_pkg::*;

  localparam int RING_DEPTH  = 256;
  localparam int ID_LEN      = 2;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  localparam int N_DIR       = 24;

  // request codes with no operation behind them
  localparam logic [2:0] REQ_RSVD_LO = 3'd5;
  localparam logic [2:0] REQ_RSVD_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  req;
    logic [15:0] id;
    logic [7:0]  len;
    logic [7:0]  wb;
    logic [7:0]  offs;
  } ring_req_s;

  typedef struct packed {
    logic [2:0] st;
    logic [7:0] rb;
    logic [7:0] fill;
    logic [7:0] free;
  } ring_res_s;

  typedef struct packed {
    ring_req_s rq;
    bit        typed;
    ring_res_s rs;
  } ring_row_s;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  req_type = '0;
  logic [15:0] object_id = '0;
  logic [7:0]  frame_len = '0;
  logic [7:0]  write_byte = '0;
  logic [7:0]  peek_offset = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [7:0]  read_byte;
  logic [7:0]  fill_count;
  logic [7:0]  free_space;

  // expectation attached to the request on offer, where typed in
  bit        cur_typed = 1'b0;
  ring_res_s cur_typed_res = '0;

  // shadow of the ring
  logic [7:0] ring_mem [0:RING_DEPTH-1];
  logic [7:0] wr_ptr = '0;
  logic [7:0] rd_ptr = '0;
  logic [7:0] pay_cnt = '0;
  logic [7:0] decl_len = '0;
  bit         frame_open = 1'b0;

  ring_res_s pending_results [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req_cnt = 0;
  int hold_ack_cnt = 0;
  int hold_left = 0;
  int sent_cnt = 0;
  int checked_cnt = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int op_cnt [0:7] = '{default: 0};
  int st_cnt [0:7] = '{default: 0};

  // directed requests; rows that read stored bytes back go to the shadow ring
  ring_row_s dir_rows [0:N_DIR-1] = '{
    '{'{REQ_POP,     16'h0000, 8'h00, 8'h00, 8'h00}, 1'b1, '{ST_UNDERFLOW, 8'h00, 8'd0, 8'd255}},
    '{'{REQ_PEEK,    16'h0000, 8'h00, 8'h00, 8'h00}, 1'b1, '{ST_UNDERFLOW, 8'h00, 8'd0, 8'd255}},
    '{'{REQ_CLOSE,   16'h0000, 8'h00, 8'h00, 8'h00}, 1'b1, '{ST_FORMAT,    8'h00, 8'd0, 8'd255}},
    '{'{REQ_OPEN,    16'hFFFF, 8'hFF, 8'h00, 8'h00}, 1'b1, '{ST_NOSPACE,   8'h00, 8'd0, 8'd255}},
    '{'{REQ_RSVD_LO, 16'h0000, 8'h00, 8'h00, 8'h00}, 1'b1, '{ST_OK,        8'h00, 8'd0, 8'd255}},
    '{'{REQ_RSVD_HI, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{ST_OK,        8'h00, 8'd0, 8'd255}},
    '{'{REQ_OPEN,    16'h0000, 8'h00, 8'h00, 8'h00}, 1'b1, '{ST_OK,        8'h00, 8'd2, 8'd253}},
    '{'{REQ_CLOSE,   16'h0000, 8'h00, 8'h00, 8'h00}, 1'b1, '{ST_OK,        8'h00, 8'd2, 8'd253}},
    '{'{REQ_WRITE,   16'h0000, 8'h00, 8'hFF, 8'h00}, 1'b1, '{ST_OK,        8'h00, 8'd3, 8'd252}},
    '{'{REQ_OPEN,    16'hFFFF, 8'h02, 8'h00, 8'h00}, 1'b1, '{ST_OK,        8'h00, 8'd5, 8'd250}},
    '{'{REQ_OPEN,    16'hA55A, 8'h01, 8'h00, 8'h00}, 1'b1, '{ST_OK,        8'h00, 8'd7, 8'd248}},
    '{'{REQ_WRITE,   16'h0000, 8'h00, 8'h00, 8'h00}, 1'b1, '{ST_OK,        8'h00, 8'd8, 8'd247}},
    '{'{REQ_WRITE,   16'h0000, 8'h00, 8'h80, 8'h00}, 1'b1, '{ST_OK,        8'h00, 8'd9, 8'd246}},
    '{'{REQ_CLOSE,   16'h0000, 8'h00, 8'h00, 8'h00}, 1'b1, '{ST_FORMAT,    8'h00, 8'd9, 8'd246}},
    '{'{REQ_PEEK,    16'h0000, 8'h00, 8'h00, 8'h08}, 1'b0, '{ST_OK,        8'h00, 8'd0, 8'd0}},
    '{'{REQ_PEEK,    16'h0000, 8'h00, 8'h00, 8'h09}, 1'b1, '{ST_UNDERFLOW, 8'h00, 8'd9, 8'd246}},
    '{'{REQ_PEEK,    16'h0000, 8'h00, 8'h00, 8'hFF}, 1'b1, '{ST_UNDERFLOW, 8'h00, 8'd9, 8'd246}},
    '{'{REQ_PEEK,    16'h0000, 8'h00, 8'h00, 8'h02}, 1'b0, '{ST_OK,        8'h00, 8'd0, 8'd0}},
    '{'{REQ_POP,     16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, '{ST_OK,        8'h00, 8'd0, 8'd0}},
    '{'{REQ_POP,     16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, '{ST_OK,        8'h00, 8'd0, 8'd0}},
    '{'{REQ_POP,     16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, '{ST_OK,        8'h00, 8'd0, 8'd0}},
    '{'{REQ_PEEK,    16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, '{ST_OK,        8'h00, 8'd0, 8'd0}},
    '{'{REQ_OPEN,    16'h0001, 8'd247, 8'h00, 8'h00}, 1'b1, '{ST_OK,       8'h00, 8'd8, 8'd247}},
    '{'{REQ_OPEN,    16'h0002, 8'd246, 8'h00, 8'h00}, 1'b1, '{ST_NOSPACE,  8'h00, 8'd8, 8'd247}}
  };

  framed_byte_ring_buffer #(
    .DEPTH    (RING_DEPTH),
    .ID_BYTES (ID_LEN)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .object_id   (object_id),
    .frame_len   (frame_len),
    .write_byte  (write_byte),
    .peek_offset (peek_offset),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .read_byte   (read_byte),
    .fill_count  (fill_count),
    .free_space  (free_space)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] ring_fill();
    return wr_ptr - rd_ptr;
  endfunction

  function automatic logic [7:0] ring_free();
    return rd_ptr - wr_ptr - 8'd1;
  endfunction

  task automatic ring_push(input logic [7:0] b);
    ring_mem[wr_ptr] = b;
    wr_ptr = wr_ptr + 8'd1;
  endtask

  // apply one request to the shadow ring and work out its result
  task automatic ring_predict(input ring_req_s rq, output ring_res_s rs);
    int need;
    logic [7:0] idx;
    rs = '0;
    rs.st = ST_OK;
    case (rq.req)
      REQ_OPEN: begin
        need = ID_LEN + int'(rq.len);
        if (int'(ring_free()) < need) begin
          rs.st = ST_NOSPACE;
        end else begin
          // id low byte first, bytes past the second are zero
          for (int i = 0; i < ID_LEN; i++) begin
            ring_push((i < 2) ? rq.id[8*(i%2) +: 8] : 8'h00);
          end
          pay_cnt = '0;
          decl_len = rq.len;
          frame_open = 1'b1;
        end
      end
      REQ_WRITE: begin
        if (ring_free() == 8'd0) begin
          rs.st = ST_OVERFLOW;
        end else begin
          ring_push(rq.wb);
          if (pay_cnt != 8'hFF) pay_cnt = pay_cnt + 8'd1;
        end
      end
      REQ_CLOSE: begin
        if (!frame_open || pay_cnt != decl_len) rs.st = ST_FORMAT;
        frame_open = 1'b0;
      end
      REQ_PEEK: begin
        if (rq.offs >= ring_fill()) begin
          rs.st = ST_UNDERFLOW;
        end else begin
          idx = rd_ptr + rq.offs;
          rs.rb = ring_mem[idx];
        end
      end
      REQ_POP: begin
        if (ring_fill() == 8'd0) begin
          rs.st = ST_UNDERFLOW;
        end else begin
          rs.rb = ring_mem[rd_ptr];
          rd_ptr = rd_ptr + 8'd1;
        end
      end
      default: begin
      end
    endcase
    rs.fill = ring_fill();
    rs.free = ring_free();
  endtask

  function automatic ring_req_s mk_req(input int unsigned req, input int unsigned id,
                                       input int unsigned len, input int unsigned wb,
                                       input int unsigned offs);
    ring_req_s r;
    r.req = 3'(req);
    r.id = 16'(id);
    r.len = 8'(len);
    r.wb = 8'(wb);
    r.offs = 8'(offs);
    return r;
  endfunction

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // offer one request from a falling edge and hold it until the transfer
  task automatic send_item(input ring_req_s rq, input bit typed, input ring_res_s tres);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq.req;
    object_id <= rq.id;
    frame_len <= rq.len;
    write_byte <= rq.wb;
    peek_offset <= rq.offs;
    cur_typed <= typed;
    cur_typed_res <= tres;
    do @(posedge clk); while (!(in_valid && in_ready));
    sent_cnt++;
    @(negedge clk);
  endtask

  // sender stops until every result is back
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // random frames (some malformed), read bursts and noise until the request count is reached
  task automatic run_phase(input int tx_pct, input int rx_pct, input bit hold_rx,
                           input int n_end);
    int pick;
    int p;
    int flen;
    int nwr;
    int nrd;
    int fl;
    int offs;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    if (hold_rx) hold_req_cnt++;
    while (sent_cnt < n_end) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        // frame: open, payload bytes, mostly a close, now and then a count off by one
        p = $urandom_range(99);
        flen = (p < 70) ? $urandom_range(24) :
               (p < 90) ? $urandom_range(120, 25) : $urandom_range(255, 121);
        send_item(mk_req(REQ_OPEN, $urandom(), flen, $urandom(), $urandom()), 1'b0, '0);
        nwr = flen;
        p = $urandom_range(99);
        if (p < 10 && flen > 0) nwr = flen - 1;
        else if (p < 20) nwr = flen + 1;
        repeat (nwr) begin
          send_item(mk_req(REQ_WRITE, $urandom(), $urandom(), $urandom(), $urandom()),
                    1'b0, '0);
        end
        if ($urandom_range(99) >= 5) begin
          send_item(mk_req(REQ_CLOSE, $urandom(), $urandom(), $urandom(), $urandom()),
                    1'b0, '0);
        end
      end else if (pick < 85) begin
        // read burst: pops and peeks, mostly inside the stored bytes
        nrd = $urandom_range(int'(ring_fill()) + 3, 1);
        repeat (nrd) begin
          if ($urandom_range(99) < 65) begin
            send_item(mk_req(REQ_POP, $urandom(), $urandom(), $urandom(), $urandom()),
                      1'b0, '0);
          end else begin
            fl = int'(ring_fill());
            offs = (fl != 0 && $urandom_range(99) < 85) ? $urandom_range(fl - 1) :
                   $urandom_range(255);
            send_item(mk_req(REQ_PEEK, $urandom(), $urandom(), $urandom(), offs),
                      1'b0, '0);
          end
        end
      end else begin
        // noise: any code, any fields
        send_item(mk_req($urandom_range(7), $urandom(), $urandom(), $urandom(), $urandom()),
                  1'b0, '0);
      end
    end
    wait_drain();
  endtask

  // receiver: long hold-off on request, else random stalls
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt <= hold_req_cnt;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    ring_req_s acc_rq;
    ring_res_s pred;
    ring_res_s want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        acc_rq = {req_type, object_id, frame_len, write_byte, peek_offset};
        ring_predict(acc_rq, pred);
        want = cur_typed ? cur_typed_res : pred;
        pending_results.push_back(want);
        op_cnt[acc_rq.req]++;
        st_cnt[want.st]++;
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          flag_error($sformatf("result with nothing outstanding: status %0d byte %02h",
                               status, read_byte));
        end else begin
          want = pending_results.pop_front();
          checked_cnt++;
          if (status !== want.st || read_byte !== want.rb ||
              fill_count !== want.fill || free_space !== want.free) begin
            flag_error($sformatf({"result %0d: expected status %0d byte %02h fill %0d ",
                                  "free %0d, got status %0d byte %02h fill %0d free %0d"},
                                 checked_cnt, want.st, want.rb, want.fill, want.free,
                                 status, read_byte, fill_count, free_space));
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("framed_byte_ring_buffer_tb: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed requests
    tx_idle_pct = 23;
    rx_idle_pct = 79;
    for (int i = 0; i < N_DIR; i++) begin
      send_item(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].rs);
    end

    // long payload run past the count saturation, popping to keep room
    send_item(mk_req(REQ_OPEN, $urandom(), 0, $urandom(), $urandom()), 1'b0, '0);
    repeat (256) begin
      if (ring_fill() > 8'd200) begin
        send_item(mk_req(REQ_POP, $urandom(), $urandom(), $urandom(), $urandom()), 1'b0, '0);
      end
      send_item(mk_req(REQ_WRITE, $urandom(), $urandom(), $urandom(), $urandom()), 1'b0, '0);
    end
    send_item(mk_req(REQ_CLOSE, $urandom(), $urandom(), $urandom(), $urandom()), 1'b0, '0);

    run_phase(23, 79, 1'b0, 500);
    run_phase(79, 23, 1'b0, 800);
    run_phase(0, 0, 1'b1, 1100);

    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    end

    $display("covered %0d requests: %0d open, %0d write, %0d close, %0d peek, %0d pop, %0d other",
             sent_cnt, op_cnt[REQ_OPEN], op_cnt[REQ_WRITE], op_cnt[REQ_CLOSE],
             op_cnt[REQ_PEEK], op_cnt[REQ_POP], sent_cnt - op_cnt[REQ_OPEN] -
             op_cnt[REQ_WRITE] - op_cnt[REQ_CLOSE] - op_cnt[REQ_PEEK] - op_cnt[REQ_POP]);
    $display("status mix %0d ok, %0d no space, %0d overflow, %0d underflow, %0d format; %0d mismatches",
             st_cnt[ST_OK], st_cnt[ST_NOSPACE], st_cnt[ST_OVERFLOW], st_cnt[ST_UNDERFLOW],
             st_cnt[ST_FORMAT], err_cnt);
    if (err_cnt == 0) begin
      $display("framed_byte_ring_buffer_tb: done, clean");
    end else begin
      $display("framed_byte_ring_buffer_tb: done, errors");
    end
    $finish;
  end

endmodule
